>>> design/lsps_pkg.sv
// ----------------------------------------------------------------------------
// lsps_pkg: shared types and codes for the LED status priority sequencer
// Beat structs, opcode and pattern codes, source indices and status codes.
// ----------------------------------------------------------------------------
package lsps_pkg;

	localparam int TICKS_PER_SECOND_DEF = 100;
	localparam int SOURCE_COUNT_DEF     = 16;

	localparam int WHICH_W  = 5;
	localparam int STATUS_W = 4;
	localparam int PWR_W    = 2;
	localparam int MSG_W    = 3;
	localparam int STEP_W   = 3;
	localparam int DWELL_W  = 12;

	// soft blink runs through six ROM steps
	localparam logic [STEP_W-1:0] SB_LAST = 3'd5;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_TICK  = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		PAT_NONE      = 4'd0,
		PAT_ON        = 4'd1,
		PAT_FLASH_ON  = 4'd2,
		PAT_FLASH_OFF = 4'd3,
		PAT_VFAST     = 4'd4,
		PAT_FAST      = 4'd5,
		PAT_NORMAL    = 4'd6,
		PAT_SLOW      = 4'd7,
		PAT_SOFTBLINK = 4'd8,
		PAT_SOFTFLASH = 4'd9
	} pat_t;

	// source indices
	localparam int SRC_DEVICE    = 0;
	localparam int SRC_CHARGER   = 2;
	localparam int SRC_MAIL_WAIT = 3;
	localparam int SRC_MAIL_SEND = 4;
	localparam int SRC_DALARM    = 5;
	localparam int SRC_SALARM    = 6;
	localparam int SRC_PWR_OVR   = 7;
	localparam int SRC_MSG_OVR   = 8;
	localparam int SRC_COMM      = 9;
	localparam int SRC_BROWSER   = 10;

	// status codes
	localparam logic [STATUS_W-1:0] ST_NONE      = 4'd0;
	localparam logic [STATUS_W-1:0] DEV_SUSPEND  = 4'd1;
	localparam logic [STATUS_W-1:0] DEV_OFF      = 4'd2;
	localparam logic [STATUS_W-1:0] CHG_ON       = 4'd1;
	localparam logic [STATUS_W-1:0] CHG_ERR      = 4'd2;
	localparam logic [STATUS_W-1:0] LINK_ACTIVE  = 4'd1;
	localparam logic [STATUS_W-1:0] LINK_ERR     = 4'd2;
	localparam logic [STATUS_W-1:0] POVR_OFF     = 4'd1;
	localparam logic [STATUS_W-1:0] POVR_ON      = 4'd2;
	localparam logic [STATUS_W-1:0] POVR_FAST    = 4'd3;
	localparam logic [STATUS_W-1:0] POVR_SLOW    = 4'd4;
	localparam logic [STATUS_W-1:0] MOVR_OFF     = 4'd1;
	localparam logic [STATUS_W-1:0] MOVR_FIRST   = 4'd2;
	localparam logic [STATUS_W-1:0] MOVR_LAST    = 4'd8;
	localparam logic [STATUS_W-1:0] MOVR_SBLINK  = 4'd9;
	localparam logic [STATUS_W-1:0] MOVR_SFLASH  = 4'd10;

	// power LED modes
	localparam logic [PWR_W-1:0] PWR_OFF  = 2'd0;
	localparam logic [PWR_W-1:0] PWR_ON   = 2'd1;
	localparam logic [PWR_W-1:0] PWR_FAST = 2'd2;
	localparam logic [PWR_W-1:0] PWR_SLOW = 2'd3;

	// message LED modes used directly by the sequencer
	localparam logic [MSG_W-1:0] MSG_OFF = 3'd0;
	localparam logic [MSG_W-1:0] MSG_ON  = 3'd1;

	typedef struct packed {
		opcode_t               opcode;
		logic [WHICH_W-1:0]    which;
		logic [STATUS_W-1:0]   status;
	} in_t;

	typedef struct packed {
		logic [PWR_W-1:0] power_led_mode;
		logic [MSG_W-1:0] message_led_mode;
		logic             bad_index;
	} out_t;

	// decision from the status store for the beat in stage 1
	typedef struct packed {
		logic             wr_en;
		logic             bad;
		logic [PWR_W-1:0] power;
		pat_t             pattern;
	} decide_t;

endpackage

>>> design/led_status_priority_sequencer_unit.sv
// ----------------------------------------------------------------------------
// led_status_priority_sequencer_unit: status LED priority sequencer
// Stores per-source status codes, drives power and message LED modes and
// steps soft blink patterns on timer ticks. One result beat per input beat.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------
//  in      | in_valid / in_ready     | in_data  (opcode, which, status)
//  out     | out_valid / out_ready   | out_data (power, message, bad_index)
//
// A beat waits in the input register, is resolved there against the
// store and the sequencer state, and its result lands in the output register:
// one beat per cycle sustained while the output is not stalled.
// Reset clears the store, the modes and the pattern timer at once.
// A stalled output holds both registers; input is taken whenever stage 1
// is empty or moving on.
module led_status_priority_sequencer_unit #(
	parameter int TICKS_PER_SECOND = lsps_pkg::TICKS_PER_SECOND_DEF,
	parameter int SOURCE_COUNT     = lsps_pkg::SOURCE_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lsps_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output lsps_pkg::out_t out_data
);

	logic                       valid_s1;
	lsps_pkg::in_t              item_s1;
	logic                       out_valid_q;
	lsps_pkg::out_t             out_data_q;
	logic                       advance;
	logic                       fire;
	lsps_pkg::decide_t          decide;
	logic [lsps_pkg::PWR_W-1:0] power_nxt;
	logic [lsps_pkg::MSG_W-1:0] msg_nxt;

	assign advance   = !out_valid_q || out_ready;
	assign fire      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	lsps_store #(
		.SOURCE_COUNT (SOURCE_COUNT)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.decide (decide)
	);

	lsps_seq #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.opcode    (item_s1.opcode),
		.decide    (decide),
		.power_nxt (power_nxt),
		.msg_nxt   (msg_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q.power_led_mode   <= power_nxt;
			out_data_q.message_led_mode <= msg_nxt;
			out_data_q.bad_index        <= decide.bad;
		end
	end

	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("result beat missing after stage 1 fired");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("stage 1 beat lost while output stalled");

	a_bad_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && decide.bad) |=> out_data_q.bad_index)
		else $error("rejected write not flagged");

	a_tick_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.opcode == lsps_pkg::OP_TICK) |=> !out_data_q.bad_index)
		else $error("tick flagged as bad index");

endmodule

>>> design/lsps_store.sv
// ----------------------------------------------------------------------------
// lsps_store: per-source status store and priority decision
// Holds one status code per source, and resolves the power LED mode and
// message pattern from the store as it stands after the current write.
// ----------------------------------------------------------------------------
module lsps_store #(
	parameter int SOURCE_COUNT = lsps_pkg::SOURCE_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  lsps_pkg::in_t    item,
	output lsps_pkg::decide_t decide
);

	localparam int IDX_W = $clog2(SOURCE_COUNT);

	logic [lsps_pkg::STATUS_W-1:0] status_q [SOURCE_COUNT];
	logic [lsps_pkg::STATUS_W-1:0] view     [SOURCE_COUNT];
	logic                          is_write;
	logic                          bad;
	logic                          wr_en;
	logic [IDX_W-1:0]              idx;
	logic [lsps_pkg::STATUS_W-1:0] povr;
	logic [lsps_pkg::STATUS_W-1:0] movr;
	logic                          dev_off;
	logic                          any_err;
	logic                          any_active;
	logic                          any_notice;

	assign is_write = (item.opcode == lsps_pkg::OP_WRITE);
	assign bad      = (item.which >= lsps_pkg::WHICH_W'(SOURCE_COUNT));
	assign wr_en    = is_write && !bad;
	assign idx      = item.which[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SOURCE_COUNT; i++) begin
				status_q[i] <= lsps_pkg::ST_NONE;
			end
		end else if (fire && wr_en) begin
			status_q[idx] <= item.status;
		end
	end

	// decisions see the code being written this beat
	always_comb begin
		for (int i = 0; i < SOURCE_COUNT; i++) begin
			view[i] = (wr_en && idx == IDX_W'(i)) ? item.status : status_q[i];
		end
	end

	assign povr    = view[lsps_pkg::SRC_PWR_OVR];
	assign movr    = view[lsps_pkg::SRC_MSG_OVR];
	assign dev_off = (view[lsps_pkg::SRC_DEVICE] == lsps_pkg::DEV_OFF);

	assign any_err =
		(view[lsps_pkg::SRC_MAIL_SEND] == lsps_pkg::LINK_ERR) ||
		(view[lsps_pkg::SRC_COMM]      == lsps_pkg::LINK_ERR) ||
		(view[lsps_pkg::SRC_BROWSER]   == lsps_pkg::LINK_ERR);
	assign any_active =
		(view[lsps_pkg::SRC_MAIL_SEND] == lsps_pkg::LINK_ACTIVE) ||
		(view[lsps_pkg::SRC_COMM]      == lsps_pkg::LINK_ACTIVE) ||
		(view[lsps_pkg::SRC_BROWSER]   == lsps_pkg::LINK_ACTIVE);
	assign any_notice =
		(view[lsps_pkg::SRC_MAIL_WAIT] != lsps_pkg::ST_NONE) ||
		(view[lsps_pkg::SRC_DALARM]    != lsps_pkg::ST_NONE) ||
		(view[lsps_pkg::SRC_SALARM]    != lsps_pkg::ST_NONE);

	always_comb begin
		decide.wr_en = wr_en;
		decide.bad   = is_write && bad;

		case (povr)
			lsps_pkg::POVR_OFF:  decide.power = lsps_pkg::PWR_OFF;
			lsps_pkg::POVR_ON:   decide.power = lsps_pkg::PWR_ON;
			lsps_pkg::POVR_FAST: decide.power = lsps_pkg::PWR_FAST;
			lsps_pkg::POVR_SLOW: decide.power = lsps_pkg::PWR_SLOW;
			default: begin
				if (view[lsps_pkg::SRC_CHARGER] == lsps_pkg::CHG_ON) begin
					decide.power = lsps_pkg::PWR_ON;
				end else if (view[lsps_pkg::SRC_CHARGER] == lsps_pkg::CHG_ERR) begin
					decide.power = lsps_pkg::PWR_FAST;
				end else begin
					decide.power = lsps_pkg::PWR_OFF;
				end
			end
		endcase

		if (movr == lsps_pkg::MOVR_OFF) begin
			decide.pattern = lsps_pkg::PAT_NONE;
		end else if (movr >= lsps_pkg::MOVR_FIRST && movr <= lsps_pkg::MOVR_LAST) begin
			// override codes 2..8 map onto patterns 1..7
			decide.pattern = lsps_pkg::pat_t'(movr - 4'd1);
		end else if (movr == lsps_pkg::MOVR_SBLINK) begin
			decide.pattern = dev_off ? lsps_pkg::PAT_NONE : lsps_pkg::PAT_SOFTBLINK;
		end else if (movr == lsps_pkg::MOVR_SFLASH) begin
			decide.pattern = dev_off ? lsps_pkg::PAT_NONE : lsps_pkg::PAT_SOFTFLASH;
		end else if (dev_off) begin
			decide.pattern = lsps_pkg::PAT_NONE;
		end else if (any_err) begin
			decide.pattern = lsps_pkg::PAT_FAST;
		end else if (any_active) begin
			decide.pattern = lsps_pkg::PAT_ON;
		end else if (any_notice) begin
			decide.pattern = lsps_pkg::PAT_SOFTBLINK;
		end else if (view[lsps_pkg::SRC_DEVICE] == lsps_pkg::DEV_SUSPEND) begin
			decide.pattern = lsps_pkg::PAT_SOFTFLASH;
		end else begin
			decide.pattern = lsps_pkg::PAT_NONE;
		end
	end

endmodule

>>> design/lsps_seq.sv
// ----------------------------------------------------------------------------
// lsps_seq: LED mode registers and soft pattern step sequencer
// Holds the current power and message modes, the active pattern, its step
// and the dwell countdown; soft patterns step through a small ROM on ticks.
// ----------------------------------------------------------------------------
module lsps_seq #(
	parameter int TICKS_PER_SECOND = lsps_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  lsps_pkg::opcode_t            opcode,
	input  lsps_pkg::decide_t            decide,
	output logic [lsps_pkg::PWR_W-1:0]   power_nxt,
	output logic [lsps_pkg::MSG_W-1:0]   msg_nxt
);

	localparam int DW = lsps_pkg::DWELL_W;
	localparam logic [DW-1:0] DW_ON_SHORT = DW'(TICKS_PER_SECOND / 10);
	localparam logic [DW-1:0] DW_OFF_MED  = DW'(TICKS_PER_SECOND / 5);
	localparam logic [DW-1:0] DW_OFF_LONG = DW'(TICKS_PER_SECOND * 2);
	localparam logic [DW-1:0] DW_FL_ON    = DW'(TICKS_PER_SECOND / 20);
	localparam logic [DW-1:0] DW_FL_OFF   =
		DW'(TICKS_PER_SECOND * 2 - TICKS_PER_SECOND / 20);

	logic [lsps_pkg::PWR_W-1:0]  power_q;
	logic [lsps_pkg::MSG_W-1:0]  msg_q;
	lsps_pkg::pat_t              pat_q, pat_nxt;
	logic [lsps_pkg::STEP_W-1:0] step_q, step_nxt;
	logic [DW-1:0]               dwell_q, dwell_nxt;

	lsps_pkg::pat_t              play_pat;
	logic [lsps_pkg::STEP_W-1:0] play_pos;
	logic [lsps_pkg::STEP_W-1:0] rom_idx;
	logic                        rom_hit;
	logic [lsps_pkg::MSG_W-1:0]  rom_mode;
	logic [DW-1:0]               rom_dwell;
	logic [lsps_pkg::STEP_W-1:0] rom_next;
	logic                        is_write;
	logic                        play;

	assign is_write = (opcode == lsps_pkg::OP_WRITE);

	// a write restarts the new pattern at step 0
	assign play_pat = is_write ? decide.pattern : pat_q;
	assign play_pos = is_write ? '0 : step_q;

	always_comb begin
		rom_idx   = '0;
		rom_hit   = 1'b0;
		rom_mode  = lsps_pkg::MSG_OFF;
		rom_dwell = '0;
		rom_next  = '0;
		case (play_pat)
			lsps_pkg::PAT_SOFTBLINK: begin
				rom_hit   = 1'b1;
				rom_idx   = (play_pos > lsps_pkg::SB_LAST) ? '0 : play_pos;
				rom_mode  = rom_idx[0] ? lsps_pkg::MSG_OFF : lsps_pkg::MSG_ON;
				if (rom_idx == lsps_pkg::SB_LAST) begin
					rom_dwell = DW_OFF_LONG;
					rom_next  = '0;
				end else begin
					rom_dwell = rom_idx[0] ? DW_OFF_MED : DW_ON_SHORT;
					rom_next  = rom_idx + 3'd1;
				end
			end
			lsps_pkg::PAT_SOFTFLASH: begin
				rom_hit   = 1'b1;
				rom_idx   = {2'b00, play_pos[0]};
				rom_mode  = rom_idx[0] ? lsps_pkg::MSG_OFF : lsps_pkg::MSG_ON;
				rom_dwell = rom_idx[0] ? DW_FL_OFF : DW_FL_ON;
				rom_next  = {2'b00, ~rom_idx[0]};
			end
			default: begin
				rom_hit = 1'b0;
			end
		endcase
	end

	always_comb begin
		power_nxt = power_q;
		msg_nxt   = msg_q;
		pat_nxt   = pat_q;
		step_nxt  = step_q;
		dwell_nxt = dwell_q;
		play      = 1'b0;
		if (fire) begin
			if (decide.wr_en) begin
				power_nxt = decide.power;
				pat_nxt   = decide.pattern;
				step_nxt  = '0;
				dwell_nxt = '0;
				if (decide.pattern == lsps_pkg::PAT_NONE) begin
					msg_nxt = lsps_pkg::MSG_OFF;
				end else if (rom_hit) begin
					play = 1'b1;
				end else begin
					msg_nxt = decide.pattern[lsps_pkg::MSG_W-1:0];
				end
			end else if (!is_write && dwell_q != '0) begin
				dwell_nxt = dwell_q - DW'(1);
				play      = (dwell_q == DW'(1));
			end
		end
		// a step with zero dwell holds its mode and stops the timer
		if (play && rom_hit) begin
			msg_nxt = rom_mode;
			if (rom_dwell != '0) begin
				dwell_nxt = rom_dwell;
				step_nxt  = rom_next;
			end else begin
				dwell_nxt = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q <= lsps_pkg::PWR_OFF;
			msg_q   <= lsps_pkg::MSG_OFF;
			pat_q   <= lsps_pkg::PAT_NONE;
			step_q  <= '0;
			dwell_q <= '0;
		end else begin
			power_q <= power_nxt;
			msg_q   <= msg_nxt;
			pat_q   <= pat_nxt;
			step_q  <= step_nxt;
			dwell_q <= dwell_nxt;
		end
	end

endmodule
